// ----- rtl/palette_fade_remap_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the palette fade remap unit
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PALETTE_FADE_REMAP_UNIT_ASSERT_SVH
`define PALETTE_FADE_REMAP_UNIT_ASSERT_SVH

// same-cycle implication
`define PFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfr assertion failed");

// next-cycle implication
`define PFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfr assertion failed");

`endif

// ----- rtl/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfr_pkg;

    localparam int SHADOW_COUNT = 16;
    localparam int PALETTE_SIZE = 256;
    localparam int SHADOW_START = (PALETTE_SIZE > SHADOW_COUNT) ?
                                  (PALETTE_SIZE - SHADOW_COUNT) : 0;

    localparam int IDX_W  = 8;
    localparam int PTR_W  = 9;   // can hold PALETTE_SIZE itself
    localparam int DIST_W = 18;  // 3 * 255^2 fits

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_LOOKUP = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ADDR_IN    = 2'd0,
        ADDR_TGT   = 2'd1,
        ADDR_START = 2'd2,
        ADDR_SCAN  = 2'd3
    } addr_sel_t;

    typedef struct packed {
        logic      accept;
        addr_sel_t addr_sel;
        logic      cap_src;
        logic      do_blend;
        logic      scan_init;
        logic      scan_step;
        logic      out_load;
    } pfr_cmd_t;

    typedef struct packed {
        logic req_lookup;
        logic fast_path;
        logic scan_last;
        logic out_busy;
    } pfr_status_t;

endpackage

// ----- rtl/pfr_datapath.sv -----
// ----------------------------------------------------------------------------
// pfr_datapath
// Palette memory, fade blend, shadow-range distance scan and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfr_datapath
    import pfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pfr_cmd_t          cmd,
    output pfr_status_t       status,
    input  logic [7:0]        fade_color,
    input  logic [7:0]        fade_fraction,
    input  logic              req_type,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  source_index,
    output logic [IDX_W-1:0]  remap_value
);

    logic [23:0]       mem [PALETTE_SIZE];
    logic [23:0]       rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  match_reg;
    logic [23:0]       src_reg;
    logic [7:0]        blend_r_reg, blend_g_reg, blend_b_reg;
    logic [PTR_W-1:0]  scan_ptr_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [DIST_W-1:0] best_reg;
    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_src_reg;
    logic [IDX_W-1:0]  out_remap_reg;

    logic              tgt_in_range;
    logic [23:0]       tgt;
    logic [7:0]        blend_r, blend_g, blend_b;
    logic [DIST_W-1:0] dist_sum;
    logic              fast_zero;

    // c + floor((t - c) * f / 256); the top bits of the product are the floor shift
    function automatic logic [7:0] blend_comp(input logic [7:0] c, input logic [7:0] t,
                                             input logic [7:0] f);
        logic signed [8:0]  diff;
        logic signed [8:0]  fs;
        logic signed [17:0] prod;
        logic [9:0]         sum;
        diff = $signed({1'b0, t}) - $signed({1'b0, c});
        fs   = $signed({1'b0, f});
        prod = diff * fs;
        sum  = {2'b00, c} + prod[17:8];
        return sum[7:0];
    endfunction

    function automatic logic [16:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0]  d;
        logic signed [17:0] p;
        d = $signed({1'b0, a}) - $signed({1'b0, b});
        p = d * d;
        return p[16:0];
    endfunction

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_IN:    rd_addr = entry_index;
            ADDR_TGT:   rd_addr = fade_color;
            ADDR_START: rd_addr = IDX_W'(SHADOW_START);
            ADDR_SCAN:  rd_addr = scan_ptr_reg[IDX_W-1:0];
            default:    rd_addr = entry_index;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (req_type == REQ_LOAD) &&
            ({1'b0, entry_index} < PTR_W'(PALETTE_SIZE)))
        begin
            mem[entry_index] <= {red, green, blue};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // fade target outside the palette blends toward black
    assign tgt_in_range = ({1'b0, fade_color} < PTR_W'(PALETTE_SIZE));
    assign tgt          = tgt_in_range ? rd_data_reg : 24'h000000;

    assign blend_r = blend_comp(src_reg[23:16], tgt[23:16], fade_fraction);
    assign blend_g = blend_comp(src_reg[15:8],  tgt[15:8],  fade_fraction);
    assign blend_b = blend_comp(src_reg[7:0],   tgt[7:0],   fade_fraction);

    assign dist_sum = DIST_W'(sq_diff(rd_data_reg[23:16], blend_r_reg)) +
                      DIST_W'(sq_diff(rd_data_reg[15:8],  blend_g_reg)) +
                      DIST_W'(sq_diff(rd_data_reg[7:0],   blend_b_reg));

    assign fast_zero = (entry_index == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg   <= entry_index;
            match_reg <= fast_zero ? '0 : entry_index;
        end
        if (cmd.cap_src)
        begin
            src_reg <= rd_data_reg;
        end
        if (cmd.do_blend)
        begin
            blend_r_reg <= blend_r;
            blend_g_reg <= blend_g;
            blend_b_reg <= blend_b;
        end
        if (cmd.scan_init)
        begin
            scan_ptr_reg <= PTR_W'(SHADOW_START + 1);
            cmp_idx_reg  <= IDX_W'(SHADOW_START);
            best_reg     <= '1;     // above any reachable distance
            match_reg    <= IDX_W'(SHADOW_START);
        end
        else if (cmd.scan_step)
        begin
            scan_ptr_reg <= scan_ptr_reg + 1'b1;
            cmp_idx_reg  <= scan_ptr_reg[IDX_W-1:0];
            // strict compare keeps the lowest index on a tie
            if (dist_sum < best_reg)
            begin
                best_reg  <= dist_sum;
                match_reg <= cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_src_reg   <= idx_reg;
            out_remap_reg <= match_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign source_index = out_src_reg;
    assign remap_value  = out_remap_reg;

    assign status.req_lookup = (req_type == REQ_LOOKUP);
    assign status.fast_path  = fast_zero || ({1'b0, entry_index} >= PTR_W'(SHADOW_START));
    assign status.scan_last  = (cmp_idx_reg == IDX_W'(PALETTE_SIZE - 1));
    assign status.out_busy   = out_valid_reg && out_stall;

endmodule

// ----- rtl/pfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfr_ctrl
// Sequencer for palette loads and remap lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "palette_fade_remap_unit_assert.svh"

module pfr_ctrl
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pfr_status_t status,
    output pfr_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RD_TGT = 5'b00010,
        S_BLEND  = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.addr_sel  = ADDR_IN;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && status.req_lookup)
                begin
                    state_next = status.fast_path ? S_DONE : S_RD_TGT;
                end
            end
            S_RD_TGT:
            begin
                cmd.addr_sel = ADDR_TGT;
                cmd.cap_src  = 1'b1;
                state_next   = S_BLEND;
            end
            S_BLEND:
            begin
                cmd.addr_sel  = ADDR_START;
                cmd.do_blend  = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.addr_sel  = ADDR_SCAN;
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `PFR_ASSERT_NEXT(a_load_stays_idle, clk, rst_n, cmd.accept && !status.req_lookup, state_reg == S_IDLE)
    `PFR_ASSERT_NEXT(a_slow_lookup_reads, clk, rst_n, cmd.accept && status.req_lookup && !status.fast_path, state_reg == S_RD_TGT)
    `PFR_ASSERT_NEXT(a_scan_continues, clk, rst_n, state_reg == S_SCAN && !status.scan_last, state_reg == S_SCAN)
    `PFR_ASSERT_NEXT(a_done_waits, clk, rst_n, state_reg == S_DONE && status.out_busy, state_reg == S_DONE)

endmodule

// ----- rtl/palette_fade_remap_unit.sv -----
// ----------------------------------------------------------------------------
// palette_fade_remap_unit
// Loadable RGB palette with a fade-and-nearest-shadow remap lookup.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  req_type, entry_index, red, green, blue
//   out      source     out_valid/out_stall  source_index, remap_value
//   cfg      APB slave  psel/penable/pready  fade_color @0x0, fade_fraction @0x4
//
// A load is written into the palette memory as it is accepted. A lookup of index
// zero or of the shadow range goes from the accept straight to the output stage;
// any other lookup runs in order: the accept reads the source color, then the fade
// target is read, then the blend, then one shadow entry per cycle through the single
// read port of the palette memory, and last the move into the output register.
// Reset clears control and the two registers; palette contents stay unknown
// until loaded. A stalled output holds the result and the next transaction is
// taken only once it has moved into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_fade_remap_unit
    import pfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              req_type,
    input  logic [IDX_W-1:0]  entry_index,
    input  logic [7:0]        red,
    input  logic [7:0]        green,
    input  logic [7:0]        blue,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  source_index,
    output logic [IDX_W-1:0]  remap_value
);

    localparam logic REG_FADE_COLOR    = 1'b0;
    localparam logic REG_FADE_FRACTION = 1'b1;

    logic [7:0]  fade_color_reg;
    logic [7:0]  fade_fraction_reg;
    logic        cfg_write;
    pfr_cmd_t    cmd;
    pfr_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // fraction is 8 bits, so the clamp to 255 is implicit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_color_reg    <= '0;
            fade_fraction_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FADE_COLOR:    fade_color_reg    <= pwdata[7:0];
                REG_FADE_FRACTION: fade_fraction_reg <= pwdata[7:0];
                default:           fade_color_reg    <= fade_color_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FADE_COLOR:    prdata = {24'h000000, fade_color_reg};
            REG_FADE_FRACTION: prdata = {24'h000000, fade_fraction_reg};
            default:           prdata = '0;
        endcase
    end

    pfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pfr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .fade_color    (fade_color_reg),
        .fade_fraction (fade_fraction_reg),
        .req_type      (req_type),
        .entry_index   (entry_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_index  (source_index),
        .remap_value   (remap_value)
    );

endmodule

// ----- verif/tb_palette_fade_remap_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_palette_fade_remap_unit
// Self-checking bench for the palette fade remap unit. Loads and lookups go
// in through the valid/stall input, and the fade registers are set over APB
// while the unit is idle. Each lookup result is compared in order with a
// bench-side prediction: the fade blend, then a nearest-shadow search. Runs
// directed corner cases, randomized traffic with random idle and back-pressure
// on both sides, and one long output hold that fills the unit.
// ----------------------------------------------------------------------------

module tb_palette_fade_remap_unit;
    import pfr_pkg::*;

    localparam logic [2:0] REG_FADE_COLOR    = 3'h0;
    localparam logic [2:0] REG_FADE_FRACTION = 3'h4;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 30;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [IDX_W-1:0] source_index;
        logic [IDX_W-1:0] remap_value;
    } remap_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              out_valid;
    logic              out_stall;
    logic [IDX_W-1:0]  source_index;
    logic [IDX_W-1:0]  remap_value;

    // bench copy of the unit state
    logic [23:0]       palette_model [PALETTE_SIZE];
    bit                loaded [PALETTE_SIZE];
    logic [7:0]        fade_color_q;
    logic [7:0]        fade_fraction_q;
    remap_result_t     pending_remaps [$];

    int unsigned       mismatch_count;
    int unsigned       idle_cycles = 0;
    int unsigned       hold_left;
    bit                idle_on;

    palette_fade_remap_unit u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned draw_idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] draw_color();
        logic [23:0] rgb;
        rgb = 24'($urandom);
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 9))
                0:       rgb[8*k +: 8] = 8'h00;
                1:       rgb[8*k +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return rgb;
    endfunction

    // fade toward the target color, then pick the closest shadow entry
    function automatic logic [IDX_W-1:0] predict_remap(input logic [IDX_W-1:0] idx);
        logic [23:0] src_rgb;
        logic [23:0] tgt_rgb;
        int          blended [3];
        int          base;
        int          target;
        int          diff;
        int          dist_sum;
        int          best_dist;
        int          match;
        if (idx == '0)
            return '0;
        if (int'(idx) >= SHADOW_START)
            return idx;
        src_rgb = palette_model[idx];
        tgt_rgb = palette_model[fade_color_q];
        // fraction is 8 bits wide, so the clamp to 255 never bites
        for (int k = 0; k < 3; k++)
        begin
            base       = int'(src_rgb[8*k +: 8]);
            target     = int'(tgt_rgb[8*k +: 8]);
            blended[k] = base + (((target - base) * int'(fade_fraction_q)) >>> 8);
        end
        best_dist = 32'h7FFF_FFFF;
        match     = SHADOW_START;
        for (int j = SHADOW_START; j < PALETTE_SIZE; j++)
        begin
            dist_sum = 0;
            for (int k = 0; k < 3; k++)
            begin
                diff = int'(palette_model[j][8*k +: 8]) - blended[k];
                dist_sum += diff * diff;
            end
            // strict compare keeps the lowest index on a tie
            if (dist_sum < best_dist)
            begin
                best_dist = dist_sum;
                match     = j;
            end
        end
        return match[IDX_W-1:0];
    endfunction

    task automatic send_request(input req_type_t kind, input logic [7:0] idx,
                                input logic [23:0] rgb);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? draw_idle_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid           = 1'b1;
        req_type           = kind;
        entry_index        = idx;
        {red, green, blue} = rgb;
        do @(posedge clk); while (in_stall);
        if (kind == REQ_LOAD)
        begin
            palette_model[idx] = rgb;
            loaded[idx]        = 1'b1;
        end
        else
            pending_remaps.push_back('{idx, predict_remap(idx)});
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_remaps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == REG_FADE_COLOR)
            fade_color_q = value;
        else
            fade_fraction_q = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // registers only change with nothing in flight; loads leave no result,
    // so give the unit time to finish after the last lookup comes out
    task automatic set_fade(input logic [7:0] color, input logic [7:0] frac);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(REG_FADE_COLOR, color);
        write_register(REG_FADE_FRACTION, frac);
    endtask

    task automatic randomize_fade();
        logic [7:0] color;
        logic [7:0] frac;
        do color = 8'($urandom_range(0, 255)); while (!loaded[color]);
        case ($urandom_range(0, 5))
            0:       frac = 8'h00;
            1:       frac = 8'hFF;
            2:       frac = 8'h80;
            default: frac = 8'($urandom_range(1, 254));
        endcase
        set_fade(color, frac);
    endtask

    task automatic send_random_item();
        logic [7:0]  idx;
        logic [23:0] rgb;
        int unsigned roll;
        rgb  = draw_color();
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
                idx = 8'd0;
            else if (roll < 30)
                idx = 8'($urandom_range(SHADOW_START, PALETTE_SIZE - 1));
            else
                idx = 8'($urandom_range(1, SHADOW_START - 1));
            // copied shadow colors give exact ties in the search
            if (int'(idx) >= SHADOW_START && $urandom_range(0, 99) < 30)
                rgb = palette_model[$urandom_range(SHADOW_START, PALETTE_SIZE - 1)];
            send_request(REQ_LOAD, idx, rgb);
        end
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                idx = 8'd0;
            else if (roll < 23)
                idx = 8'($urandom_range(SHADOW_START, PALETTE_SIZE - 1));
            else
                idx = 8'($urandom_range(1, SHADOW_START - 1));
            // an unloaded source must be loaded before anything reads it
            if (!loaded[idx])
                send_request(REQ_LOAD, idx, rgb);
            else
                send_request(REQ_LOOKUP, idx, rgb);
        end
    endtask

    task automatic test_shadow_setup();
        logic [23:0] rgb;
        for (int j = SHADOW_START; j < PALETTE_SIZE; j++)
        begin
            case (j - SHADOW_START)
                0:       rgb = 24'h000000;
                1, 2:    rgb = 24'h404040;
                3:       rgb = 24'hFF0000;
                4:       rgb = 24'h00FF00;
                5:       rgb = 24'h0000FF;
                15:      rgb = 24'hFFFFFF;
                default: rgb = {3{8'(16 * (j - SHADOW_START))}};
            endcase
            send_request(REQ_LOAD, 8'(j), rgb);
        end
    endtask

    task automatic test_fast_paths();
        send_request(REQ_LOOKUP, 8'd0, 24'hFFFFFF);
        send_request(REQ_LOOKUP, 8'(SHADOW_START), 24'h000000);
        send_request(REQ_LOOKUP, 8'hFF, 24'hA5A5A5);
    endtask

    task automatic test_blend_extremes();
        send_request(REQ_LOAD, 8'd0,   24'h000000);
        send_request(REQ_LOAD, 8'd1,   24'hFFFFFF);
        send_request(REQ_LOAD, 8'd2,   24'h404040);
        send_request(REQ_LOAD, 8'd128, 24'h7F8081);
        send_request(REQ_LOAD, 8'(SHADOW_START - 1), 24'h8001FE);
        // no fade: plain nearest match, including a tie on two equal shadows
        set_fade(8'd0, 8'd0);
        send_request(REQ_LOOKUP, 8'd1, 24'h000000);
        send_request(REQ_LOOKUP, 8'd2, 24'hFFFFFF);
        send_request(REQ_LOOKUP, 8'(SHADOW_START - 1), 24'h000000);
        // full fade toward white
        set_fade(8'hFF, 8'hFF);
        send_request(REQ_LOOKUP, 8'd128, 24'h000000);
        send_request(REQ_LOOKUP, 8'(SHADOW_START - 1), 24'hFFFFFF);
        // full fade toward black: negative step rounds down
        set_fade(8'd0, 8'hFF);
        send_request(REQ_LOOKUP, 8'd1, 24'h000000);
        send_request(REQ_LOOKUP, 8'd128, 24'h000000);
        set_fade(8'd1, 8'h80);
        send_request(REQ_LOOKUP, 8'(SHADOW_START - 1), 24'h000000);
        send_request(REQ_LOOKUP, 8'd2, 24'h000000);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++)
        begin
            randomize_fade();
            idle_on = (phase != 2);
            for (int n = 0; n < 100; n++)
            begin
                send_random_item();
                if (phase == 3 && n == 50)
                    wait_drained();
            end
        end
    endtask

    task automatic test_output_backpressure();
        logic [7:0] idx;
        idle_on   = 1'b1;
        hold_left = LONG_HOLD;
        for (int n = 0; n < 40; n++)
        begin
            do idx = 8'($urandom_range(0, 255)); while (!loaded[idx]);
            send_request(REQ_LOOKUP, idx, draw_color());
        end
    endtask

    initial
    begin : rx_stall_gen
        int unsigned stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 99) < 25)
            begin
                out_stall  = 1'b1;
                stall_left = draw_idle_len() - 1;
            end
            else
                out_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        remap_result_t seen;
        remap_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{source_index, remap_value};
            if (pending_remaps.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: source_index %0d remap_value %0d",
                             seen.source_index, seen.remap_value);
            end
            else
            begin
                want = pending_remaps.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: expected source %0d remap %0d, got source %0d remap %0d",
                                 want.source_index, want.remap_value,
                                 seen.source_index, seen.remap_value);
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_palette_fade_remap_unit failed");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        req_type        = REQ_LOAD;
        entry_index     = '0;
        red             = '0;
        green           = '0;
        blue            = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        idle_on         = 1'b0;
        hold_left       = 0;
        mismatch_count  = 0;
        fade_color_q    = '0;
        fade_fraction_q = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_shadow_setup();
        test_fast_paths();
        test_blend_extremes();
        test_random_traffic();
        test_output_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_remaps.size() == 0)
            $display("tb_palette_fade_remap_unit passed");
        else
            $display("tb_palette_fade_remap_unit failed");
        $finish;
    end

endmodule
